// File: hdl/sbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbt_pkg: shared types and constants
// Slot record, controller states and register indexes for the blob tracker.
// ---------------------------------------------------------------------------
package sbt_pkg;

  localparam int unsigned TrackSlotsDef = 32;

  localparam int unsigned AreaW = 20;
  localparam int unsigned CtrW  = 16;
  localparam int unsigned HalfW = 15;   // halved center
  localparam int unsigned BoxW  = 12;
  localparam int unsigned HitW  = 16;
  localparam int unsigned MissW = 8;
  localparam int unsigned FracW = 8;
  localparam int unsigned CfgIdxW = 3;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegMinArea  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAreaFrac = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCtrFrac  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxMiss  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAlarmHit = 3'd4;

  // command codes
  localparam logic CmdDetect   = 1'b0;
  localparam logic CmdEndFrame = 1'b1;

  typedef struct packed {
    logic             active;
    logic             hit;
    logic [AreaW-2:0] area;    // halved area
    logic [HalfW-1:0] cx;
    logic [HalfW-1:0] cy;
    logic [BoxW-1:0]  bx;
    logic [BoxW-1:0]  by;
    logic [BoxW-1:0]  bw;
    logic [BoxW-1:0]  bh;
    logic [HitW-1:0]  hits;
    logic [MissW-1:0] miss;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET,
    ST_FILL,
    ST_EOF,
    ST_FLUSH
  } state_e;

endpackage
`default_nettype wire

// File: hdl/static_blob_track_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// static_blob_track_table: tracked blob table for static object alarms
// Chain of slot cells rotated past one shared match and update unit.
// ---------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start_i is high and busy_o is low.
//   A detection (command 0) rotates the slot chain once past the match unit
//   with busy_o high, then fills a free slot in ST_FILL when nothing matched.
//   A detection not above min_area is absorbed in the accept cycle. An end
//   of frame (command 1) rotates the chain once, updating miss counts and
//   freeing stale slots, then passes through ST_FLUSH with busy_o still high.
//   Each alarmed box goes out once the next one is found; the final result is
//   strobed in the first cycle with busy_o low. The next command can be taken
//   in that same cycle; no new command is taken while one is in progress, as
//   busy_o stays high while the chain rotates through the single head cell.
//   Each result stands for one cycle with alarm_strobe_o high; the receiver
//   cannot stall. last_of_frame_o marks the final result of a frame; with no
//   alarm a single empty marker (alarm_valid_o low) is sent.
//   Configuration beats on cfg_valid_i/cfg_ready_o are always taken; write
//   them only while busy_o is low. Unknown indexes are ignored.
//   Reset empties the table and loads default register values.
// ---------------------------------------------------------------------------
module static_blob_track_table #(
  parameter int unsigned TRACK_SLOTS = sbt_pkg::TrackSlotsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic                           command_i,
  input  wire logic [sbt_pkg::AreaW-1:0]      blob_area_i,
  input  wire logic [sbt_pkg::CtrW-1:0]       blob_center_x_i,
  input  wire logic [sbt_pkg::CtrW-1:0]       blob_center_y_i,
  input  wire logic [sbt_pkg::BoxW-1:0]       det_box_x_i,
  input  wire logic [sbt_pkg::BoxW-1:0]       det_box_y_i,
  input  wire logic [sbt_pkg::BoxW-1:0]       det_box_w_i,
  input  wire logic [sbt_pkg::BoxW-1:0]       det_box_h_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sbt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sbt_pkg::AreaW-1:0]      cfg_data_i,
  output logic                                alarm_strobe_o,
  output logic                                alarm_valid_o,
  output logic [sbt_pkg::BoxW-1:0]            alarm_box_x_o,
  output logic [sbt_pkg::BoxW-1:0]            alarm_box_y_o,
  output logic [sbt_pkg::BoxW-1:0]            alarm_box_w_o,
  output logic [sbt_pkg::BoxW-1:0]            alarm_box_h_o,
  output logic                                last_of_frame_o
);
  import sbt_pkg::*;

  localparam int unsigned IdxW = $clog2(TRACK_SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TRACK_SLOTS - 1);

  // configuration registers
  logic [AreaW-1:0] min_area_q;
  logic [FracW-1:0] area_frac_q, ctr_frac_q;
  logic [MissW-1:0] max_miss_q;
  logic [HitW-1:0]  alarm_hits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_area_q   <= AreaW'(200);
      area_frac_q  <= FracW'(51);
      ctr_frac_q   <= FracW'(51);
      max_miss_q   <= MissW'(4);
      alarm_hits_q <= HitW'(45);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMinArea:  min_area_q   <= cfg_data_i;
        RegAreaFrac: area_frac_q  <= cfg_data_i[FracW-1:0];
        RegCtrFrac:  ctr_frac_q   <= cfg_data_i[FracW-1:0];
        RegMaxMiss:  max_miss_q   <= cfg_data_i[MissW-1:0];
        RegAlarmHit: alarm_hits_q <= cfg_data_i[HitW-1:0];
        default: ;
      endcase
    end
  end

  // controller
  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic            matched_q, free_q;
  logic [IdxW-1:0] free_idx_q;
  logic            take, det_go, eof_go, last_step;
  logic            shift_en, fill_en, det_phase, eof_phase;
  logic            head_match, head_hit, fill_go, head_alarm;
  slot_t           cell_q [TRACK_SLOTS];
  slot_t           head, head_upd, new_slot;

  // captured detection
  logic [AreaW-2:0] det_area_q;
  logic [HalfW-1:0] det_cx_q, det_cy_q;
  logic [BoxW-1:0]  det_bx_q, det_by_q, det_bw_q, det_bh_q;

  assign take      = start_i && !busy_o;
  assign det_go    = take && (command_i == CmdDetect) && (blob_area_i > min_area_q);
  assign eof_go    = take && (command_i == CmdEndFrame);
  assign last_step = (idx_q == LastIdx);
  assign head      = cell_q[0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (det_go) begin
          state_d = ST_DET;
        end else if (eof_go) begin
          state_d = ST_EOF;
        end
      end
      ST_DET: begin
        if (last_step) begin
          state_d = fill_go ? ST_FILL : ST_IDLE;
        end
      end
      ST_FILL:  state_d = ST_IDLE;
      ST_EOF:   if (last_step) state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o    = 1'b1;
    det_phase = 1'b0;
    eof_phase = 1'b0;
    fill_en   = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy_o    = 1'b0;
      ST_DET:   det_phase = 1'b1;
      ST_FILL:  fill_en   = 1'b1;
      ST_EOF:   eof_phase = 1'b1;
      ST_FLUSH: ;
      default:  busy_o    = 1'b0;
    endcase
    shift_en = det_phase || eof_phase;
  end

  // shared match unit on the head cell
  sbt_match u_match (
    .slot_area_i (head.area),
    .slot_cx_i   (head.cx),
    .slot_cy_i   (head.cy),
    .det_area_i  (det_area_q),
    .det_cx_i    (det_cx_q),
    .det_cy_i    (det_cy_q),
    .area_frac_i (area_frac_q),
    .ctr_frac_i  (ctr_frac_q),
    .match_o     (head_match)
  );

  assign head_hit = det_phase && head.active && head_match && !matched_q;
  assign fill_go  = !matched_q && !head_hit && (free_q || !head.active);

  // head update on its way back to the tail
  always_comb begin
    head_upd = head;
    if (head_hit) begin
      head_upd.hit = 1'b1;
      if (head.hits != '1) begin
        head_upd.hits = head.hits + HitW'(1);
      end
    end
    if (eof_phase && head.active) begin
      if (head.hit) begin
        head_upd.miss = '0;
      end else if (head.miss != '1) begin
        head_upd.miss = head.miss + MissW'(1);
      end
      head_upd.hit = 1'b0;
      if (head_upd.miss > max_miss_q) begin
        head_upd.active = 1'b0;
      end
    end
  end

  assign head_alarm = eof_phase && head_upd.active && (head_upd.hits > alarm_hits_q);

  // record for a new track
  always_comb begin
    new_slot        = '0;
    new_slot.active = 1'b1;
    new_slot.hit    = 1'b1;
    new_slot.area   = det_area_q;
    new_slot.cx     = det_cx_q;
    new_slot.cy     = det_cy_q;
    new_slot.bx     = det_bx_q;
    new_slot.by     = det_by_q;
    new_slot.bw     = det_bw_q;
    new_slot.bh     = det_bh_q;
    new_slot.hits   = HitW'(1);
  end

  // chain of cells, shifting toward cell zero
  for (genvar i = 0; i < TRACK_SLOTS; i++) begin : g_cell
    slot_t nb;
    if (i == TRACK_SLOTS - 1) begin : g_tail
      assign nb = head_upd;
    end else begin : g_body
      assign nb = cell_q[i+1];
    end
    sbt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift_en),
      .shift_d_i (nb),
      .load_i    (fill_en && (free_idx_q == IdxW'(i))),
      .load_d_i  (new_slot),
      .slot_o    (cell_q[i])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      matched_q <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        idx_q     <= '0;
        matched_q <= 1'b0;
        free_q    <= 1'b0;
      end else if (shift_en) begin
        idx_q <= last_step ? '0 : idx_q + IdxW'(1);
        if (head_hit) matched_q <= 1'b1;
        if (det_phase && !head.active) free_q <= 1'b1;
      end
    end
  end

  // lowest free slot and detection capture
  always_ff @(posedge clk_i) begin
    if (det_phase && !head.active && !free_q) begin
      free_idx_q <= idx_q;
    end
    if (take) begin
      det_area_q <= blob_area_i[AreaW-1:1];
      det_cx_q   <= blob_center_x_i[CtrW-1:1];
      det_cy_q   <= blob_center_y_i[CtrW-1:1];
      det_bx_q   <= det_box_x_i;
      det_by_q   <= det_box_y_i;
      det_bw_q   <= det_box_w_i;
      det_bh_q   <= det_box_h_i;
    end
  end

  // result beats: one alarm held back so the last can be marked
  logic            pend_q, strobe_q, valid_q, last_q;
  logic [BoxW-1:0] pbx_q, pby_q, pbw_q, pbh_q;
  logic [BoxW-1:0] obx_q, oby_q, obw_q, obh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (head_alarm && pend_q) || (state_q == ST_FLUSH);
      if (head_alarm) begin
        pend_q <= 1'b1;
      end else if (state_q == ST_FLUSH) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_alarm) begin
      obx_q   <= pbx_q;
      oby_q   <= pby_q;
      obw_q   <= pbw_q;
      obh_q   <= pbh_q;
      valid_q <= 1'b1;
      last_q  <= 1'b0;
      pbx_q   <= head.bx;
      pby_q   <= head.by;
      pbw_q   <= head.bw;
      pbh_q   <= head.bh;
    end else if (state_q == ST_FLUSH) begin
      obx_q   <= pend_q ? pbx_q : '0;
      oby_q   <= pend_q ? pby_q : '0;
      obw_q   <= pend_q ? pbw_q : '0;
      obh_q   <= pend_q ? pbh_q : '0;
      valid_q <= pend_q;
      last_q  <= 1'b1;
    end
  end

  assign alarm_strobe_o  = strobe_q;
  assign alarm_valid_o   = valid_q;
  assign alarm_box_x_o   = obx_q;
  assign alarm_box_y_o   = oby_q;
  assign alarm_box_w_o   = obw_q;
  assign alarm_box_h_o   = obh_q;
  assign last_of_frame_o = last_q;

endmodule
`default_nettype wire

// File: hdl/sbt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbt_cell: one slot of the track chain
// Holds one slot record; shifts in its neighbor's record or takes a direct load.
// ---------------------------------------------------------------------------
module sbt_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          shift_i,
  input  wire sbt_pkg::slot_t shift_d_i,
  input  wire logic          load_i,
  input  wire sbt_pkg::slot_t load_d_i,
  output sbt_pkg::slot_t     slot_o
);
  import sbt_pkg::*;

  slot_t slot_q, slot_d;

  // load wins over shift
  always_comb begin
    slot_d = slot_q;
    if (load_i) begin
      slot_d = load_d_i;
    end else if (shift_i) begin
      slot_d = shift_d_i;
    end
  end

  // slot record; empty and cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// File: hdl/sbt_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbt_match: slot versus detection test
// Cross-multiplied area change and squared center shift tests.
// ---------------------------------------------------------------------------
module sbt_match (
  input  wire logic [sbt_pkg::AreaW-2:0] slot_area_i,
  input  wire logic [sbt_pkg::HalfW-1:0] slot_cx_i,
  input  wire logic [sbt_pkg::HalfW-1:0] slot_cy_i,
  input  wire logic [sbt_pkg::AreaW-2:0] det_area_i,
  input  wire logic [sbt_pkg::HalfW-1:0] det_cx_i,
  input  wire logic [sbt_pkg::HalfW-1:0] det_cy_i,
  input  wire logic [sbt_pkg::FracW-1:0] area_frac_i,
  input  wire logic [sbt_pkg::FracW-1:0] ctr_frac_i,
  output logic                           match_o
);
  import sbt_pkg::*;

  localparam int unsigned ProdW = AreaW + FracW + 1;
  localparam int unsigned SqW   = 2 * HalfW + 1;

  logic [AreaW-2:0] d;
  logic [HalfW-1:0] dx, dy;
  logic [ProdW-1:0] d_scaled, area_lim, ctr_lim;
  logic [SqW-1:0]   sq_shift;
  logic             area_ok, ctr_ok;

  // absolute differences
  assign d  = (slot_area_i > det_area_i) ? slot_area_i - det_area_i : det_area_i - slot_area_i;
  assign dx = (slot_cx_i > det_cx_i) ? slot_cx_i - det_cx_i : det_cx_i - slot_cx_i;
  assign dy = (slot_cy_i > det_cy_i) ? slot_cy_i - det_cy_i : det_cy_i - slot_cy_i;

  // area test: d*256 < frac*(slot_area+1)
  assign d_scaled = ProdW'({d, 8'd0});
  assign area_lim = ProdW'(area_frac_i) * ProdW'({1'b0, slot_area_i} + AreaW'(1));
  assign area_ok  = d_scaled < area_lim;

  // center test: dx^2+dy^2 < frac*(det_area+1), compared at full square width
  assign sq_shift = SqW'(dx) * SqW'(dx) + SqW'(dy) * SqW'(dy);
  assign ctr_lim  = ProdW'(ctr_frac_i) * ProdW'({1'b0, det_area_i} + AreaW'(1));
  assign ctr_ok   = sq_shift < SqW'(ctr_lim);

  assign match_o = area_ok && ctr_ok;

endmodule
`default_nettype wire

// File: dv/sbt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbt_checker: result predictor and scoreboard for the blob track table
// Watches command, config and alarm beats, tracks the slot table itself and
// compares every alarm beat against the oldest predicted one.
// ---------------------------------------------------------------------------
module sbt_checker
  import sbt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_o,
  input  wire logic               command_i,
  input  wire logic [AreaW-1:0]   blob_area_i,
  input  wire logic [CtrW-1:0]    blob_center_x_i,
  input  wire logic [CtrW-1:0]    blob_center_y_i,
  input  wire logic [BoxW-1:0]    det_box_x_i,
  input  wire logic [BoxW-1:0]    det_box_y_i,
  input  wire logic [BoxW-1:0]    det_box_w_i,
  input  wire logic [BoxW-1:0]    det_box_h_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [AreaW-1:0]   cfg_data_i,
  input  wire logic               alarm_strobe_o,
  input  wire logic               alarm_valid_o,
  input  wire logic [BoxW-1:0]    alarm_box_x_o,
  input  wire logic [BoxW-1:0]    alarm_box_y_o,
  input  wire logic [BoxW-1:0]    alarm_box_w_o,
  input  wire logic [BoxW-1:0]    alarm_box_h_o,
  input  wire logic               last_of_frame_o,
  output int                      fail_count,
  output int                      pending_alarms
);

  localparam int Slots = 32;

  typedef struct packed {
    logic            vld;
    logic [BoxW-1:0] x;
    logic [BoxW-1:0] y;
    logic [BoxW-1:0] w;
    logic [BoxW-1:0] h;
    logic            last;
  } alarm_t;

  alarm_t alarm_q[$];

  // predictor copy of the registers and the table
  logic [AreaW-1:0] min_area_r;
  logic [FracW-1:0] area_frac_r, ctr_frac_r;
  logic [MissW-1:0] max_miss_r;
  logic [HitW-1:0]  alarm_hits_r;
  slot_t            tbl [Slots];

  assign pending_alarms = alarm_q.size();

  task automatic track_detection(input logic [AreaW-1:0] area,
                                 input logic [CtrW-1:0] cx_in, input logic [CtrW-1:0] cy_in,
                                 input logic [BoxW-1:0] bx, input logic [BoxW-1:0] by,
                                 input logic [BoxW-1:0] bw, input logic [BoxW-1:0] bh);
    logic [63:0] ah, cx, cy, sa, d, dx, dy;
    bit area_ok, ctr_ok;
    ah = area >> 1;
    cx = cx_in >> 1;
    cy = cy_in >> 1;
    if (area <= min_area_r) return;
    for (int s = 0; s < Slots; s++) begin
      if (tbl[s].active) begin
        sa = tbl[s].area;
        d  = (sa > ah) ? sa - ah : ah - sa;
        dx = (tbl[s].cx > cx) ? tbl[s].cx - cx : cx - tbl[s].cx;
        dy = (tbl[s].cy > cy) ? tbl[s].cy - cy : cy - tbl[s].cy;
        area_ok = d * 256 < area_frac_r * (sa + 1);
        ctr_ok  = dx * dx + dy * dy < ctr_frac_r * (ah + 1);
        if (area_ok && ctr_ok) begin
          tbl[s].hit = 1'b1;
          if (tbl[s].hits != '1) tbl[s].hits++;
          return;
        end
      end
    end
    for (int s = 0; s < Slots; s++) begin
      if (!tbl[s].active) begin
        tbl[s] = '{active: 1'b1, hit: 1'b1, area: ah[AreaW-2:0],
                   cx: cx[HalfW-1:0], cy: cy[HalfW-1:0],
                   bx: bx, by: by, bw: bw, bh: bh, hits: HitW'(1), miss: '0};
        return;
      end
    end
  endtask

  task automatic close_frame();
    alarm_t a;
    int n;
    n = 0;
    for (int s = 0; s < Slots; s++) begin
      if (tbl[s].active) begin
        if (tbl[s].hit) tbl[s].miss = '0;
        else if (tbl[s].miss != '1) tbl[s].miss++;
        tbl[s].hit = 1'b0;
        if (tbl[s].miss > max_miss_r) tbl[s].active = 1'b0;
      end
    end
    for (int s = 0; s < Slots; s++) begin
      if (tbl[s].active && tbl[s].hits > alarm_hits_r) begin
        a = '{1'b1, tbl[s].bx, tbl[s].by, tbl[s].bw, tbl[s].bh, 1'b0};
        alarm_q = {alarm_q, a};
        n++;
      end
    end
    if (n == 0) begin
      a = '0;
      alarm_q = {alarm_q, a};
    end
    alarm_q[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alarm_t got, exp_a;
    if (!rst_ni) begin
      min_area_r   <= AreaW'(200);
      area_frac_r  <= FracW'(51);
      ctr_frac_r   <= FracW'(51);
      max_miss_r   <= MissW'(4);
      alarm_hits_r <= HitW'(45);
      for (int s = 0; s < Slots; s++) tbl[s] = '0;
      alarm_q.delete();
      fail_count = 0;
    end else begin
      // result beat against oldest prediction
      if (alarm_strobe_o) begin
        got = '{alarm_valid_o, alarm_box_x_o, alarm_box_y_o, alarm_box_w_o,
                alarm_box_h_o, last_of_frame_o};
        if (alarm_q.size() == 0) begin
          $display("%0t: unexpected alarm beat %h", $time, got);
          fail_count++;
        end else begin
          exp_a = alarm_q.pop_front();
          if (got !== exp_a) begin
            $display("%0t: alarm mismatch exp vld=%b x=%0d y=%0d w=%0d h=%0d last=%b",
                     $time, exp_a.vld, exp_a.x, exp_a.y, exp_a.w, exp_a.h, exp_a.last);
            $display("%0t:                got vld=%b x=%0d y=%0d w=%0d h=%0d last=%b",
                     $time, got.vld, got.x, got.y, got.w, got.h, got.last);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegMinArea:  min_area_r   <= cfg_data_i;
          RegAreaFrac: area_frac_r  <= cfg_data_i[FracW-1:0];
          RegCtrFrac:  ctr_frac_r   <= cfg_data_i[FracW-1:0];
          RegMaxMiss:  max_miss_r   <= cfg_data_i[MissW-1:0];
          RegAlarmHit: alarm_hits_r <= cfg_data_i[HitW-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        if (command_i == CmdEndFrame) close_frame();
        else track_detection(blob_area_i, blob_center_x_i, blob_center_y_i,
                             det_box_x_i, det_box_y_i, det_box_w_i, det_box_h_i);
      end
    end
  end

endmodule

// File: dv/tb_static_blob_track_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_static_blob_track_table: stimulus and verdict for the blob track table
// Drives directed and random frames of detections through several register
// settings; the checker beside the block predicts and compares alarms.
// ---------------------------------------------------------------------------
module tb_static_blob_track_table;
  import sbt_pkg::*;

  logic               clk, rst_n;
  logic               start, busy, command;
  logic [AreaW-1:0]   blob_area;
  logic [CtrW-1:0]    cen_x, cen_y;
  logic [BoxW-1:0]    bx, by, bw, bh;
  logic               cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [AreaW-1:0]   cfg_data;
  logic               a_strobe, a_valid, a_last;
  logic [BoxW-1:0]    a_x, a_y, a_w, a_h;
  int                 fail_count, pending_alarms;
  int                 cycles;

  static_blob_track_table dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .command_i(command), .blob_area_i(blob_area),
    .blob_center_x_i(cen_x), .blob_center_y_i(cen_y),
    .det_box_x_i(bx), .det_box_y_i(by), .det_box_w_i(bw), .det_box_h_i(bh),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .alarm_strobe_o(a_strobe), .alarm_valid_o(a_valid),
    .alarm_box_x_o(a_x), .alarm_box_y_o(a_y), .alarm_box_w_o(a_w),
    .alarm_box_h_o(a_h), .last_of_frame_o(a_last)
  );

  sbt_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .command_i(command), .blob_area_i(blob_area),
    .blob_center_x_i(cen_x), .blob_center_y_i(cen_y),
    .det_box_x_i(bx), .det_box_y_i(by), .det_box_w_i(bw), .det_box_h_i(bh),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .alarm_strobe_o(a_strobe), .alarm_valid_o(a_valid),
    .alarm_box_x_o(a_x), .alarm_box_y_o(a_y), .alarm_box_w_o(a_w),
    .alarm_box_h_o(a_h), .last_of_frame_o(a_last),
    .fail_count(fail_count), .pending_alarms(pending_alarms)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit: the whole test, with its gaps, many times over
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 300000) begin
        $display("FAIL static_blob_track_table");
        $finish;
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  // one command beat, held until accepted; fields wrap to port width
  task automatic send_cmd(input logic cmd, input int unsigned area,
                          input int unsigned x, input int unsigned y,
                          input int unsigned b0, input int unsigned b1,
                          input int unsigned b2, input int unsigned b3);
    start = 1'b1; command = cmd; blob_area = AreaW'(area);
    cen_x = CtrW'(x); cen_y = CtrW'(y);
    bx = BoxW'(b0); by = BoxW'(b1); bw = BoxW'(b2); bh = BoxW'(b3);
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    if ($urandom_range(0, 2) != 0) idle_gap();
  endtask

  task automatic send_eof();
    send_cmd(CmdEndFrame, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom);
  endtask

  // wait until the block is quiet and all alarms are in
  task automatic drain();
    do @(negedge clk); while (busy || start || pending_alarms != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = AreaW'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input int unsigned ma, input int unsigned af,
                          input int unsigned cf, input int unsigned mm,
                          input int unsigned ah);
    drain();
    write_reg(RegMinArea, ma);
    write_reg(RegAreaFrac, af);
    write_reg(RegCtrFrac, cf);
    write_reg(RegMaxMiss, mm);
    write_reg(RegAlarmHit, ah);
  endtask

  // random frames: a few recurring blobs with jitter, plus noise detections
  task automatic random_frames(input int items);
    int unsigned base_a [4];
    int unsigned base_x [4], base_y [4];
    int k;
    for (int i = 0; i < 4; i++) begin
      base_a[i] = $urandom_range(300, 60000);
      base_x[i] = $urandom_range(0, 65535); base_y[i] = $urandom_range(0, 65535);
    end
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 5) == 0) send_eof();
      else if ($urandom_range(0, 4) == 0)
        send_cmd(CmdDetect, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      else begin
        k = $urandom_range(0, 3);
        send_cmd(CmdDetect, base_a[k] + $urandom_range(0, 6),
                 base_x[k] + $urandom_range(0, 3), base_y[k] + $urandom_range(0, 3),
                 $urandom, $urandom, $urandom, $urandom);
      end
    end
    send_eof();
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; command = CmdDetect; blob_area = '0;
    cen_x = '0; cen_y = '0; bx = '0; by = '0; bw = '0; bh = '0;
    cfg_valid = 1'b0; cfg_index = RegMinArea; cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, ignored small blob, field extremes
    send_eof();
    send_cmd(CmdDetect, 200, 16'hFFFF, 16'h0000, 0, 0, 0, 0);
    send_cmd(CmdDetect, 201, 0, 0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_cmd(CmdDetect, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 12'hABC, 12'h543, 1, 2);
    send_cmd(CmdDetect, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
    send_eof();
    // alarm on low threshold, keep stale slots forever
    set_regs(0, 8'hFF, 8'hFF, 8'hFF, 0);
    send_cmd(CmdDetect, 1, 0, 0, 1, 2, 3, 4);
    send_eof();
    // fill the whole table with spread blobs and overflow it, then one more
    set_regs(0, 0, 0, 8'hFF, 1);
    for (int i = 0; i < 33; i++)
      send_cmd(CmdDetect, 1000 + i * 50, i * 1000, 0, i, i, i, i);
    send_cmd(CmdDetect, 1000, 0, 0, 0, 0, 0, 0);
    send_eof();
    // zero misses allowed: table empties
    set_regs(20'hFFFFF, 51, 51, 0, 16'hFFFF);
    send_eof();
    drain();

    // random phases over several settings; each pauses for all alarms first
    set_regs(200, 51, 51, 4, 3);
    random_frames(20);
    drain();
    set_regs($urandom_range(0, 2000), $urandom_range(0, 255), 255,
             $urandom_range(0, 3), $urandom_range(0, 5));
    random_frames(20);
    set_regs(0, 255, 255, 2, 0);
    random_frames(20);
    drain();

    if (fail_count == 0) begin
      $display("PASS static_blob_track_table");
    end else begin
      $display("FAIL static_blob_track_table");
    end
    $finish;
  end

endmodule
